// File: hdl/pftd_pkg.sv
// Package for the page framebuffer text drawing engine.
// Holds command codes, the state enum and the 5x7 font table. No dependencies.
package pftd_pkg;

  typedef enum logic [2:0] {
    FUNC_CLEAR = 3'd0,
    FUNC_PIXEL = 3'd1,
    FUNC_FILL  = 3'd2,
    FUNC_GLYPH = 3'd3,
    FUNC_READ  = 3'd4
  } func_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_WALK,
    ST_RMW,
    ST_READ,
    ST_DONE
  } state_e;

  localparam logic [7:0] CODE_FIRST = 8'h20;
  localparam logic [7:0] CODE_LAST  = 8'h7E;
  localparam logic [7:0] CODE_QMARK = 8'h3F;
  localparam int unsigned GLYPH_COLS = 5;
  localparam int unsigned GLYPH_ROWS = 7;

  // Return one font column; code already in 0x20..0x7E
  function automatic logic [6:0] glyph_col(input logic [7:0] code, input logic [2:0] col);
    logic [34:0] g;
    g = 35'h0;
    case (code)
      8'h20: g = {7'h00,7'h00,7'h00,7'h00,7'h00};
      8'h21: g = {7'h00,7'h00,7'h5F,7'h00,7'h00};
      8'h22: g = {7'h00,7'h07,7'h00,7'h07,7'h00};
      8'h23: g = {7'h14,7'h7F,7'h14,7'h7F,7'h14};
      8'h24: g = {7'h12,7'h2A,7'h7F,7'h2A,7'h24};
      8'h25: g = {7'h62,7'h64,7'h08,7'h13,7'h23};
      8'h26: g = {7'h50,7'h22,7'h55,7'h49,7'h36};
      8'h27: g = {7'h00,7'h00,7'h03,7'h05,7'h00};
      8'h28: g = {7'h00,7'h41,7'h22,7'h1C,7'h00};
      8'h29: g = {7'h00,7'h1C,7'h22,7'h41,7'h00};
      8'h2A: g = {7'h14,7'h08,7'h3E,7'h08,7'h14};
      8'h2B: g = {7'h08,7'h08,7'h3E,7'h08,7'h08};
      8'h2C: g = {7'h00,7'h00,7'h30,7'h50,7'h00};
      8'h2D: g = {7'h08,7'h08,7'h08,7'h08,7'h08};
      8'h2E: g = {7'h00,7'h00,7'h60,7'h60,7'h00};
      8'h2F: g = {7'h02,7'h04,7'h08,7'h10,7'h20};
      8'h30: g = {7'h3E,7'h45,7'h49,7'h51,7'h3E};
      8'h31: g = {7'h00,7'h40,7'h7F,7'h42,7'h00};
      8'h32: g = {7'h46,7'h49,7'h51,7'h61,7'h42};
      8'h33: g = {7'h31,7'h4B,7'h45,7'h41,7'h21};
      8'h34: g = {7'h10,7'h7F,7'h12,7'h14,7'h18};
      8'h35: g = {7'h39,7'h45,7'h45,7'h45,7'h27};
      8'h36: g = {7'h30,7'h49,7'h49,7'h4A,7'h3C};
      8'h37: g = {7'h03,7'h05,7'h09,7'h71,7'h01};
      8'h38: g = {7'h36,7'h49,7'h49,7'h49,7'h36};
      8'h39: g = {7'h1E,7'h29,7'h49,7'h49,7'h06};
      8'h3A: g = {7'h00,7'h00,7'h36,7'h36,7'h00};
      8'h3B: g = {7'h00,7'h00,7'h36,7'h56,7'h00};
      8'h3C: g = {7'h00,7'h41,7'h22,7'h14,7'h08};
      8'h3D: g = {7'h14,7'h14,7'h14,7'h14,7'h14};
      8'h3E: g = {7'h08,7'h14,7'h22,7'h41,7'h00};
      8'h3F: g = {7'h06,7'h09,7'h51,7'h01,7'h02};
      8'h40: g = {7'h3E,7'h41,7'h79,7'h49,7'h32};
      8'h41: g = {7'h7E,7'h11,7'h11,7'h11,7'h7E};
      8'h42: g = {7'h36,7'h49,7'h49,7'h49,7'h7F};
      8'h43: g = {7'h22,7'h41,7'h41,7'h41,7'h3E};
      8'h44: g = {7'h1C,7'h22,7'h41,7'h41,7'h7F};
      8'h45: g = {7'h41,7'h49,7'h49,7'h49,7'h7F};
      8'h46: g = {7'h01,7'h09,7'h09,7'h09,7'h7F};
      8'h47: g = {7'h7A,7'h49,7'h49,7'h41,7'h3E};
      8'h48: g = {7'h7F,7'h08,7'h08,7'h08,7'h7F};
      8'h49: g = {7'h00,7'h41,7'h7F,7'h41,7'h00};
      8'h4A: g = {7'h01,7'h3F,7'h41,7'h40,7'h20};
      8'h4B: g = {7'h41,7'h22,7'h14,7'h08,7'h7F};
      8'h4C: g = {7'h40,7'h40,7'h40,7'h40,7'h7F};
      8'h4D: g = {7'h7F,7'h02,7'h0C,7'h02,7'h7F};
      8'h4E: g = {7'h7F,7'h10,7'h08,7'h04,7'h7F};
      8'h4F: g = {7'h3E,7'h41,7'h41,7'h41,7'h3E};
      8'h50: g = {7'h06,7'h09,7'h09,7'h09,7'h7F};
      8'h51: g = {7'h5E,7'h21,7'h51,7'h41,7'h3E};
      8'h52: g = {7'h46,7'h29,7'h19,7'h09,7'h7F};
      8'h53: g = {7'h31,7'h49,7'h49,7'h49,7'h46};
      8'h54: g = {7'h01,7'h01,7'h7F,7'h01,7'h01};
      8'h55: g = {7'h3F,7'h40,7'h40,7'h40,7'h3F};
      8'h56: g = {7'h1F,7'h20,7'h40,7'h20,7'h1F};
      8'h57: g = {7'h7F,7'h20,7'h18,7'h20,7'h7F};
      8'h58: g = {7'h63,7'h14,7'h08,7'h14,7'h63};
      8'h59: g = {7'h03,7'h04,7'h78,7'h04,7'h03};
      8'h5A: g = {7'h43,7'h45,7'h49,7'h51,7'h61};
      8'h5B: g = {7'h00,7'h41,7'h41,7'h7F,7'h00};
      8'h5C: g = {7'h20,7'h10,7'h08,7'h04,7'h02};
      8'h5D: g = {7'h00,7'h7F,7'h41,7'h41,7'h00};
      8'h5E: g = {7'h04,7'h02,7'h01,7'h02,7'h04};
      8'h5F: g = {7'h40,7'h40,7'h40,7'h40,7'h40};
      8'h60: g = {7'h00,7'h04,7'h02,7'h01,7'h00};
      8'h61: g = {7'h78,7'h54,7'h54,7'h54,7'h20};
      8'h62: g = {7'h38,7'h44,7'h44,7'h48,7'h7F};
      8'h63: g = {7'h20,7'h44,7'h44,7'h44,7'h38};
      8'h64: g = {7'h7F,7'h48,7'h44,7'h44,7'h38};
      8'h65: g = {7'h18,7'h54,7'h54,7'h54,7'h38};
      8'h66: g = {7'h02,7'h01,7'h09,7'h7E,7'h08};
      8'h67: g = {7'h3E,7'h52,7'h52,7'h52,7'h0C};
      8'h68: g = {7'h78,7'h04,7'h04,7'h08,7'h7F};
      8'h69: g = {7'h00,7'h40,7'h7D,7'h44,7'h00};
      8'h6A: g = {7'h00,7'h3D,7'h44,7'h40,7'h20};
      8'h6B: g = {7'h00,7'h44,7'h28,7'h10,7'h7F};
      8'h6C: g = {7'h00,7'h40,7'h7F,7'h41,7'h00};
      8'h6D: g = {7'h78,7'h04,7'h18,7'h04,7'h7C};
      8'h6E: g = {7'h78,7'h04,7'h04,7'h08,7'h7C};
      8'h6F: g = {7'h38,7'h44,7'h44,7'h44,7'h38};
      8'h70: g = {7'h08,7'h14,7'h14,7'h14,7'h7C};
      8'h71: g = {7'h7C,7'h18,7'h14,7'h14,7'h08};
      8'h72: g = {7'h08,7'h04,7'h04,7'h08,7'h7C};
      8'h73: g = {7'h20,7'h54,7'h54,7'h54,7'h48};
      8'h74: g = {7'h20,7'h40,7'h44,7'h3F,7'h04};
      8'h75: g = {7'h7C,7'h20,7'h40,7'h40,7'h3C};
      8'h76: g = {7'h1C,7'h20,7'h40,7'h20,7'h1C};
      8'h77: g = {7'h3C,7'h40,7'h30,7'h40,7'h3C};
      8'h78: g = {7'h44,7'h28,7'h10,7'h28,7'h44};
      8'h79: g = {7'h3C,7'h50,7'h50,7'h50,7'h0C};
      8'h7A: g = {7'h44,7'h4C,7'h54,7'h64,7'h44};
      8'h7B: g = {7'h00,7'h41,7'h36,7'h08,7'h00};
      8'h7C: g = {7'h00,7'h00,7'h7F,7'h00,7'h00};
      8'h7D: g = {7'h00,7'h08,7'h36,7'h41,7'h00};
      8'h7E: g = {7'h08,7'h10,7'h08,7'h04,7'h08};
      default: g = 35'h0;
    endcase
    case (col)
      3'd0: glyph_col = g[6:0];
      3'd1: glyph_col = g[13:7];
      3'd2: glyph_col = g[20:14];
      3'd3: glyph_col = g[27:21];
      3'd4: glyph_col = g[34:28];
      default: glyph_col = 7'h0;
    endcase
  endfunction

endpackage

// File: hdl/page_framebuffer_text_draw.sv
// Drawing engine top level: command sequencer around one frame store memory.
// Uses pftd_pkg for codes and the font table.
// Clear sweeps the whole store to zero, read fetches one byte, pixel writes one point
// if on panel, and an empty fill or spare code goes straight to done. Fill and glyph
// visit every candidate of the unclipped box (glyph: 35*sx*sy), with a read-modify-write
// per drawn on-panel pixel. One command at a time; the receiver cannot stall, busy is high
// through done_o. Reset clears control, then sweeps the store to zero.
module page_framebuffer_text_draw #(
  parameter int PANEL_WIDTH  = 128,
  parameter int PANEL_HEIGHT = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] func_i,
  input  logic signed [8:0] x_pos_i,
  input  logic signed [8:0] y_pos_i,
  input  logic [7:0] rect_width_i,
  input  logic [7:0] rect_height_i,
  input  logic       pixel_on_i,
  input  logic [7:0] char_code_i,
  input  logic [3:0] scale_x_i,
  input  logic [3:0] scale_y_i,
  input  logic [9:0] byte_addr_i,
  output logic       done_o,
  output logic [7:0] read_data_o,
  output logic       was_read_o
);

  localparam int PAGES = (PANEL_HEIGHT + 7) / 8;
  localparam int DEPTH = PANEL_WIDTH * PAGES;
  localparam int AW = $clog2(DEPTH);

  // Frame store
  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;
  logic       we;
  logic [AW-1:0] waddr, raddr;
  logic [7:0] wdata;

  // Command registers
  pftd_pkg::state_e state_q, state_d;
  logic [2:0] func_q;
  logic signed [10:0] x0_q, y0_q;
  logic [8:0] w_q, h_q;          // extent of the walk box
  logic [8:0] cx_q, cx_d, cy_q, cy_d;
  logic       lit_q;
  logic [7:0] code_q;
  logic [3:0] sx_q, sy_q;
  logic [9:0] baddr_q;
  logic [AW:0] clr_q, clr_d;
  logic [AW-1:0] pa_q;
  logic [2:0] pbit_q;
  logic       res_read_q;
  logic [7:0] res_data_q;

  // Walk position decode
  logic [2:0] gcol;
  logic [3:0] sxc, syc;
  logic [2:0] grow;
  logic [6:0] gbits;
  logic signed [10:0] px, py;
  logic       pix_on, in_panel, walk_last;
  logic [AW-1:0] paddr;

  assign sxc = (sx_q == 4'd0) ? 4'd1 : sx_q;
  assign syc = (sy_q == 4'd0) ? 4'd1 : sy_q;

  // Glyph walk carries column/row of font plus sub-offset counters
  logic [2:0] gc_q, gc_d, gr_q, gr_d;
  logic [3:0] ux_q, ux_d, uy_q, uy_d;
  assign gcol = gc_q;
  assign grow = gr_q;
  assign gbits = pftd_pkg::glyph_col(code_q, gcol);

  always_comb begin
    if (func_q == pftd_pkg::FUNC_GLYPH) begin
      px = x0_q + 11'(cx_q);
      py = y0_q + 11'(cy_q);
      pix_on = gbits[grow];
    end else begin
      px = x0_q + 11'(cx_q);
      py = y0_q + 11'(cy_q);
      pix_on = 1'b1;
    end
    in_panel = (px >= 0) && (px < 11'(PANEL_WIDTH)) && (py >= 0) && (py < 11'(PANEL_HEIGHT));
    paddr = AW'((py >>> 3) * PANEL_WIDTH + px);
    if (func_q == pftd_pkg::FUNC_GLYPH)
      walk_last = (gc_q == 3'd4) && (ux_q == sxc - 4'd1) && (gr_q == 3'd6) &&
                  (uy_q == syc - 4'd1);
    else
      walk_last = (cx_q == w_q - 9'd1) && (cy_q == h_q - 9'd1);
  end

  // Advance walk counters; glyph goes row-major inside each font cell pixel
  always_comb begin
    cx_d = cx_q; cy_d = cy_q; gc_d = gc_q; gr_d = gr_q; ux_d = ux_q; uy_d = uy_q;
    if (func_q == pftd_pkg::FUNC_GLYPH) begin
      if (ux_q != sxc - 4'd1) begin
        ux_d = ux_q + 4'd1; cx_d = cx_q + 9'd1;
      end else if (uy_q != syc - 4'd1) begin
        ux_d = 4'd0; uy_d = uy_q + 4'd1;
        cx_d = cx_q - 9'(sxc) + 9'd1; cy_d = cy_q + 9'd1;
      end else if (gr_q != 3'd6) begin
        ux_d = 4'd0; uy_d = 4'd0; gr_d = gr_q + 3'd1;
        cx_d = cx_q - 9'(sxc) + 9'd1; cy_d = cy_q + 9'd1;
      end else begin
        ux_d = 4'd0; uy_d = 4'd0; gr_d = 3'd0; gc_d = gc_q + 3'd1;
        cx_d = cx_q + 9'd1; cy_d = 9'd0;
      end
    end else begin
      if (cx_q != w_q - 9'd1) cx_d = cx_q + 9'd1;
      else begin cx_d = 9'd0; cy_d = cy_q + 9'd1; end
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    clr_d = clr_q;
    unique case (state_q)
      pftd_pkg::ST_IDLE: if (start) begin
        unique case (func_i)
          pftd_pkg::FUNC_CLEAR: begin state_d = pftd_pkg::ST_CLEAR; clr_d = '0; end
          pftd_pkg::FUNC_PIXEL, pftd_pkg::FUNC_GLYPH: state_d = pftd_pkg::ST_WALK;
          pftd_pkg::FUNC_FILL: state_d = (rect_width_i == 8'd0 || rect_height_i == 8'd0)
                                         ? pftd_pkg::ST_DONE : pftd_pkg::ST_WALK;
          pftd_pkg::FUNC_READ: state_d = pftd_pkg::ST_READ;
          default: state_d = pftd_pkg::ST_DONE;
        endcase
      end
      pftd_pkg::ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == (AW+1)'(DEPTH - 1))
          state_d = (func_q == pftd_pkg::FUNC_CLEAR) ? pftd_pkg::ST_DONE : pftd_pkg::ST_IDLE;
      end
      pftd_pkg::ST_WALK:
        if (pix_on && in_panel) state_d = pftd_pkg::ST_RMW;
        else if (walk_last) state_d = pftd_pkg::ST_DONE;
      pftd_pkg::ST_RMW: state_d = walk_last ? pftd_pkg::ST_DONE : pftd_pkg::ST_WALK;
      pftd_pkg::ST_READ: state_d = pftd_pkg::ST_DONE;
      pftd_pkg::ST_DONE: state_d = pftd_pkg::ST_IDLE;
      default: state_d = pftd_pkg::ST_IDLE;
    endcase
  end

  // Memory control; idle reads the byte address ahead so the read state sees its data
  always_comb begin
    raddr = paddr;
    if (state_q == pftd_pkg::ST_IDLE) raddr = AW'(byte_addr_i);
    we = 1'b0;
    waddr = pa_q;
    wdata = lit_q ? (rdata_q | (8'd1 << pbit_q)) : (rdata_q & ~(8'd1 << pbit_q));
    if (state_q == pftd_pkg::ST_CLEAR) begin
      we = 1'b1; waddr = clr_q[AW-1:0]; wdata = 8'd0;
    end else if (state_q == pftd_pkg::ST_RMW) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    rdata_q <= mem_q[raddr];
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pftd_pkg::ST_CLEAR;
      clr_q <= '0;
      func_q <= 3'd7;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      if (state_q == pftd_pkg::ST_IDLE && start) func_q <= func_i;
    end
  end

  // Latch command and walk counters
  always_ff @(posedge clk_i) begin
    if (state_q == pftd_pkg::ST_IDLE && start) begin
      x0_q <= 11'(x_pos_i);
      y0_q <= 11'(y_pos_i);
      lit_q <= (func_i == pftd_pkg::FUNC_GLYPH) ? 1'b1 : pixel_on_i;
      code_q <= (char_code_i < pftd_pkg::CODE_FIRST || char_code_i > pftd_pkg::CODE_LAST)
                ? pftd_pkg::CODE_QMARK : char_code_i;
      sx_q <= scale_x_i;
      sy_q <= scale_y_i;
      baddr_q <= byte_addr_i;
      w_q <= (func_i == pftd_pkg::FUNC_PIXEL) ? 9'd1 : 9'(rect_width_i);
      h_q <= (func_i == pftd_pkg::FUNC_PIXEL) ? 9'd1 : 9'(rect_height_i);
      cx_q <= '0; cy_q <= '0; gc_q <= '0; gr_q <= '0; ux_q <= '0; uy_q <= '0;
    end else if ((state_q == pftd_pkg::ST_WALK && !(pix_on && in_panel)) ||
                 state_q == pftd_pkg::ST_RMW) begin
      cx_q <= cx_d; cy_q <= cy_d; gc_q <= gc_d; gr_q <= gr_d; ux_q <= ux_d; uy_q <= uy_d;
    end
    if (state_q == pftd_pkg::ST_WALK) begin
      pa_q <= paddr;
      pbit_q <= py[2:0];
    end
    if (state_q == pftd_pkg::ST_READ) begin
      res_read_q <= 1'b1;
      res_data_q <= (32'(baddr_q) < 32'(DEPTH)) ? rdata_q : 8'd0;
    end else if (state_q == pftd_pkg::ST_IDLE) begin
      res_read_q <= 1'b0;
      res_data_q <= 8'd0;
    end
  end

  // Outputs
  always_comb begin
    busy = (state_q != pftd_pkg::ST_IDLE);
    done_o = (state_q == pftd_pkg::ST_DONE);
    read_data_o = done_o ? res_data_q : 8'd0;
    was_read_o = done_o & res_read_q;
  end

endmodule

// File: hdl/pftd_checker.sv
// Port-level checker for the drawing engine, bound to the top level.
// Depends on the top-level port names only.
module pftd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       done_o,
  input logic [7:0] read_data_o,
  input logic       was_read_o
);
  // A result ends a command, so the engine is free next cycle
  a_done_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy) else $error("busy after result");
  // A result only appears while busy
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy) else $error("result while idle");
  // Accepted word raises busy
  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accept without busy");
  // Data only on a read answer
  a_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !was_read_o |-> read_data_o == 8'd0) else $error("data without read");
endmodule

bind page_framebuffer_text_draw pftd_checker u_pftd_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .done_o(done_o),
  .read_data_o(read_data_o), .was_read_o(was_read_o)
);

// File: test/page_framebuffer_text_draw_test.sv
// Testbench for the page framebuffer drawing engine: drives commands, predicts the
// frame store in SystemVerilog and checks every result word. Depends on pftd_pkg.
module page_framebuffer_text_draw_test;

  localparam int PANEL_W    = 128;
  localparam int PANEL_H    = 64;
  localparam int STORE_SIZE = PANEL_W * ((PANEL_H + 7) / 8);
  localparam logic [2:0] FUNC_SPARE_LO = 3'd5;
  localparam logic [2:0] FUNC_SPARE_HI = 3'd7;

  typedef struct {
    logic [2:0]        func;
    logic signed [8:0] x_pos;
    logic signed [8:0] y_pos;
    logic [7:0]        rect_width;
    logic [7:0]        rect_height;
    logic              pixel_on;
    logic [7:0]        char_code;
    logic [3:0]        scale_x;
    logic [3:0]        scale_y;
    logic [9:0]        byte_addr;
  } cmd_t;

  typedef struct {
    logic [7:0] read_data;
    logic       was_read;
  } readout_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy, done_o;
  logic [2:0] func_i = '0;
  logic signed [8:0] x_pos_i = '0, y_pos_i = '0;
  logic [7:0] rect_width_i = '0, rect_height_i = '0, char_code_i = '0;
  logic pixel_on_i = 1'b0;
  logic [3:0] scale_x_i = '0, scale_y_i = '0;
  logic [9:0] byte_addr_i = '0;
  logic [7:0] read_data_o;
  logic was_read_o;

  logic [7:0] shadow_store [STORE_SIZE];
  logic [7:0] font_rom [95*5];
  readout_t   pending_readouts[$];
  int         fail_count = 0;
  int         sent_count = 0;
  int         read_count = 0;
  int         glyph_count = 0;

  page_framebuffer_text_draw #(.PANEL_WIDTH(PANEL_W), .PANEL_HEIGHT(PANEL_H)) dut (.*);

  always #5 clk_i = ~clk_i;

  // Load the 5x7 font, one byte per column, bit 0 on top
  initial begin
    logic [7:0] f [95*5];
    f = '{
      8'h00,8'h00,8'h00,8'h00,8'h00, 8'h00,8'h00,8'h5F,8'h00,8'h00, 8'h00,8'h07,8'h00,8'h07,8'h00,
      8'h14,8'h7F,8'h14,8'h7F,8'h14, 8'h24,8'h2A,8'h7F,8'h2A,8'h12, 8'h23,8'h13,8'h08,8'h64,8'h62,
      8'h36,8'h49,8'h55,8'h22,8'h50, 8'h00,8'h05,8'h03,8'h00,8'h00, 8'h00,8'h1C,8'h22,8'h41,8'h00,
      8'h00,8'h41,8'h22,8'h1C,8'h00, 8'h14,8'h08,8'h3E,8'h08,8'h14, 8'h08,8'h08,8'h3E,8'h08,8'h08,
      8'h00,8'h50,8'h30,8'h00,8'h00, 8'h08,8'h08,8'h08,8'h08,8'h08, 8'h00,8'h60,8'h60,8'h00,8'h00,
      8'h20,8'h10,8'h08,8'h04,8'h02, 8'h3E,8'h51,8'h49,8'h45,8'h3E, 8'h00,8'h42,8'h7F,8'h40,8'h00,
      8'h42,8'h61,8'h51,8'h49,8'h46, 8'h21,8'h41,8'h45,8'h4B,8'h31, 8'h18,8'h14,8'h12,8'h7F,8'h10,
      8'h27,8'h45,8'h45,8'h45,8'h39, 8'h3C,8'h4A,8'h49,8'h49,8'h30, 8'h01,8'h71,8'h09,8'h05,8'h03,
      8'h36,8'h49,8'h49,8'h49,8'h36, 8'h06,8'h49,8'h49,8'h29,8'h1E, 8'h00,8'h36,8'h36,8'h00,8'h00,
      8'h00,8'h56,8'h36,8'h00,8'h00, 8'h08,8'h14,8'h22,8'h41,8'h00, 8'h14,8'h14,8'h14,8'h14,8'h14,
      8'h00,8'h41,8'h22,8'h14,8'h08, 8'h02,8'h01,8'h51,8'h09,8'h06, 8'h32,8'h49,8'h79,8'h41,8'h3E,
      8'h7E,8'h11,8'h11,8'h11,8'h7E, 8'h7F,8'h49,8'h49,8'h49,8'h36, 8'h3E,8'h41,8'h41,8'h41,8'h22,
      8'h7F,8'h41,8'h41,8'h22,8'h1C, 8'h7F,8'h49,8'h49,8'h49,8'h41, 8'h7F,8'h09,8'h09,8'h09,8'h01,
      8'h3E,8'h41,8'h49,8'h49,8'h7A, 8'h7F,8'h08,8'h08,8'h08,8'h7F, 8'h00,8'h41,8'h7F,8'h41,8'h00,
      8'h20,8'h40,8'h41,8'h3F,8'h01, 8'h7F,8'h08,8'h14,8'h22,8'h41, 8'h7F,8'h40,8'h40,8'h40,8'h40,
      8'h7F,8'h02,8'h0C,8'h02,8'h7F, 8'h7F,8'h04,8'h08,8'h10,8'h7F, 8'h3E,8'h41,8'h41,8'h41,8'h3E,
      8'h7F,8'h09,8'h09,8'h09,8'h06, 8'h3E,8'h41,8'h51,8'h21,8'h5E, 8'h7F,8'h09,8'h19,8'h29,8'h46,
      8'h46,8'h49,8'h49,8'h49,8'h31, 8'h01,8'h01,8'h7F,8'h01,8'h01, 8'h3F,8'h40,8'h40,8'h40,8'h3F,
      8'h1F,8'h20,8'h40,8'h20,8'h1F, 8'h7F,8'h20,8'h18,8'h20,8'h7F, 8'h63,8'h14,8'h08,8'h14,8'h63,
      8'h03,8'h04,8'h78,8'h04,8'h03, 8'h61,8'h51,8'h49,8'h45,8'h43, 8'h00,8'h7F,8'h41,8'h41,8'h00,
      8'h02,8'h04,8'h08,8'h10,8'h20, 8'h00,8'h41,8'h41,8'h7F,8'h00, 8'h04,8'h02,8'h01,8'h02,8'h04,
      8'h40,8'h40,8'h40,8'h40,8'h40, 8'h00,8'h01,8'h02,8'h04,8'h00, 8'h20,8'h54,8'h54,8'h54,8'h78,
      8'h7F,8'h48,8'h44,8'h44,8'h38, 8'h38,8'h44,8'h44,8'h44,8'h20, 8'h38,8'h44,8'h44,8'h48,8'h7F,
      8'h38,8'h54,8'h54,8'h54,8'h18, 8'h08,8'h7E,8'h09,8'h01,8'h02, 8'h0C,8'h52,8'h52,8'h52,8'h3E,
      8'h7F,8'h08,8'h04,8'h04,8'h78, 8'h00,8'h44,8'h7D,8'h40,8'h00, 8'h20,8'h40,8'h44,8'h3D,8'h00,
      8'h7F,8'h10,8'h28,8'h44,8'h00, 8'h00,8'h41,8'h7F,8'h40,8'h00, 8'h7C,8'h04,8'h18,8'h04,8'h78,
      8'h7C,8'h08,8'h04,8'h04,8'h78, 8'h38,8'h44,8'h44,8'h44,8'h38, 8'h7C,8'h14,8'h14,8'h14,8'h08,
      8'h08,8'h14,8'h14,8'h18,8'h7C, 8'h7C,8'h08,8'h04,8'h04,8'h08, 8'h48,8'h54,8'h54,8'h54,8'h20,
      8'h04,8'h3F,8'h44,8'h40,8'h20, 8'h3C,8'h40,8'h40,8'h20,8'h7C, 8'h1C,8'h20,8'h40,8'h20,8'h1C,
      8'h3C,8'h40,8'h30,8'h40,8'h3C, 8'h44,8'h28,8'h10,8'h28,8'h44, 8'h0C,8'h50,8'h50,8'h50,8'h3C,
      8'h44,8'h64,8'h54,8'h4C,8'h44, 8'h00,8'h08,8'h36,8'h41,8'h00, 8'h00,8'h00,8'h7F,8'h00,8'h00,
      8'h00,8'h41,8'h36,8'h08,8'h00, 8'h08,8'h04,8'h08,8'h10,8'h08};
    font_rom = f;
    foreach (shadow_store[i]) shadow_store[i] = 8'h00;
  end

  // Shadow store update: one pixel, clipped to the panel
  task automatic paint_pixel(input int col, input int row, input bit lit);
    int a;
    if (col < 0 || col >= PANEL_W || row < 0 || row >= PANEL_H) return;
    a = (row / 8) * PANEL_W + col;
    shadow_store[a][row % 8] = lit;
  endtask

  task automatic paint_box(input int x0, input int y0, input int w, input int h,
                           input bit lit);
    int r0, r1, c0, c1;
    r0 = (y0 < 0) ? 0 : y0;
    r1 = (y0 + h > PANEL_H) ? PANEL_H : y0 + h;
    c0 = (x0 < 0) ? 0 : x0;
    c1 = (x0 + w > PANEL_W) ? PANEL_W : x0 + w;
    for (int r = r0; r < r1; r++)
      for (int c = c0; c < c1; c++) paint_pixel(c, r, lit);
  endtask

  // Apply one command to the shadow store and return the readout word it yields
  task automatic apply_command(input cmd_t c, output readout_t res);
    int sx, sy, code;
    logic [7:0] bits;
    res.read_data = 8'h00;
    res.was_read  = 1'b0;
    case (c.func)
      pftd_pkg::FUNC_CLEAR: foreach (shadow_store[i]) shadow_store[i] = 8'h00;
      pftd_pkg::FUNC_PIXEL: paint_pixel(c.x_pos, c.y_pos, c.pixel_on);
      pftd_pkg::FUNC_FILL:
        paint_box(c.x_pos, c.y_pos, c.rect_width, c.rect_height, c.pixel_on);
      pftd_pkg::FUNC_GLYPH: begin
        sx = (c.scale_x == 0) ? 1 : c.scale_x;
        sy = (c.scale_y == 0) ? 1 : c.scale_y;
        code = (c.char_code < pftd_pkg::CODE_FIRST || c.char_code > pftd_pkg::CODE_LAST)
               ? pftd_pkg::CODE_QMARK : c.char_code;
        for (int col = 0; col < pftd_pkg::GLYPH_COLS; col++) begin
          bits = font_rom[(code - pftd_pkg::CODE_FIRST) * 5 + col];
          for (int row = 0; row < pftd_pkg::GLYPH_ROWS; row++)
            if (bits[row])
              paint_box(c.x_pos + col * sx, c.y_pos + row * sy, sx, sy, 1'b1);
        end
      end
      pftd_pkg::FUNC_READ: begin
        res.was_read = 1'b1;
        if (c.byte_addr < STORE_SIZE) res.read_data = shadow_store[c.byte_addr];
      end
      default: ;
    endcase
  endtask

  // Send one command word after a gap; predict its readout once accepted
  task automatic send_command(input cmd_t c, input int gap);
    readout_t res;
    @(negedge clk_i);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    func_i = c.func;           x_pos_i = c.x_pos;         y_pos_i = c.y_pos;
    rect_width_i = c.rect_width; rect_height_i = c.rect_height;
    pixel_on_i = c.pixel_on;   char_code_i = c.char_code;
    scale_x_i = c.scale_x;     scale_y_i = c.scale_y;     byte_addr_i = c.byte_addr;
    start = 1'b1;
    do @(posedge clk_i); while (busy);
    apply_command(c, res);
    pending_readouts.push_back(res);
    sent_count++;
    if (c.func == pftd_pkg::FUNC_READ) read_count++;
    if (c.func == pftd_pkg::FUNC_GLYPH) glyph_count++;
  endtask

  function automatic cmd_t blank_cmd(input logic [2:0] f);
    cmd_t c;
    c.func = f; c.x_pos = '0; c.y_pos = '0; c.rect_width = '0; c.rect_height = '0;
    c.pixel_on = 1'b0; c.char_code = '0; c.scale_x = '0; c.scale_y = '0;
    c.byte_addr = '0;
    return c;
  endfunction

  function automatic cmd_t read_cmd(input int a);
    cmd_t c;
    c = blank_cmd(pftd_pkg::FUNC_READ);
    c.byte_addr = a[9:0];
    return c;
  endfunction

  function automatic int pick_gap();
    return ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(5, 0);
  endfunction

  // Compare each readout word with the oldest prediction
  always @(posedge clk_i) begin
    readout_t want;
    if (rst_ni && done_o) begin
      if (pending_readouts.size() == 0) begin
        $error("unexpected readout word: read_data %0h was_read %0b",
               read_data_o, was_read_o);
        fail_count++;
      end else begin
        want = pending_readouts.pop_front();
        if (read_data_o !== want.read_data) begin
          $error("read_data mismatch: expected %0h actual %0h", want.read_data, read_data_o);
          fail_count++;
        end
        if (was_read_o !== want.was_read) begin
          $error("was_read mismatch: expected %0b actual %0b", want.was_read, was_read_o);
          fail_count++;
        end
      end
    end
  end

  // Read back the byte at a drawn point, clamped to the panel
  task automatic read_near(input int x, input int y);
    int pg, col;
    pg  = (y < 0) ? 0 : (y >= PANEL_H ? PANEL_H - 1 : y) / 8;
    col = (x < 0) ? 0 : (x >= PANEL_W ? PANEL_W - 1 : x);
    send_command(read_cmd(pg * PANEL_W + col), pick_gap());
  endtask

  task automatic test_directed();
    cmd_t c;
    // fresh store reads zero at both ends
    send_command(read_cmd(0), 0);
    send_command(read_cmd(STORE_SIZE - 1), 0);
    // corner pixels, then off-panel pixels at the field extremes
    c = blank_cmd(pftd_pkg::FUNC_PIXEL); c.pixel_on = 1'b1;
    c.x_pos = 0; c.y_pos = 0; send_command(c, 0);
    c.x_pos = PANEL_W - 1; c.y_pos = PANEL_H - 1; send_command(c, 1);
    c.x_pos = -256; c.y_pos = 255; send_command(c, 0);
    c.x_pos = 255; c.y_pos = -1; send_command(c, 0);
    send_command(read_cmd(0), 0);
    send_command(read_cmd(STORE_SIZE - 1), 2);
    // full-panel fill from off-panel origin, then a zero-size fill and an unlit fill
    c = blank_cmd(pftd_pkg::FUNC_FILL); c.pixel_on = 1'b1;
    c.x_pos = -1; c.y_pos = -1; c.rect_width = 255; c.rect_height = 255;
    send_command(c, 0);
    c.x_pos = 3; c.y_pos = 3; c.rect_width = 0; c.rect_height = 9; c.pixel_on = 1'b0;
    send_command(c, 0);
    c.rect_width = 10; c.rect_height = 10;
    send_command(c, 0);
    send_command(read_cmd(3), 0);
    send_command(read_cmd(PANEL_W + 12), 0);
    // glyphs: zero scale, unprintable codes, largest scale, unlit pixels keep store
    c = blank_cmd(pftd_pkg::FUNC_GLYPH);
    c.char_code = 8'h41; c.x_pos = 20; c.y_pos = 20; send_command(c, 0);
    c.char_code = 8'h00; c.x_pos = 40; c.y_pos = 2; c.scale_x = 2; send_command(c, 0);
    c.char_code = 8'hFF; c.x_pos = -3; c.y_pos = 60; c.scale_x = 1; c.scale_y = 3;
    send_command(c, 0);
    c.char_code = 8'h7E; c.x_pos = 60; c.y_pos = 0; c.scale_x = 15; c.scale_y = 15;
    send_command(c, 0);
    send_command(read_cmd(2 * PANEL_W + 20), 0);
    send_command(read_cmd(PANEL_W + 61), 0);
    // spare codes change nothing, then clear
    c = blank_cmd(FUNC_SPARE_LO); send_command(c, 0);
    c = blank_cmd(FUNC_SPARE_HI); send_command(c, 3);
    send_command(blank_cmd(pftd_pkg::FUNC_CLEAR), 0);
    send_command(read_cmd(PANEL_W + 61), 0);
  endtask

  task automatic test_random(input int count);
    cmd_t c;
    int pick;
    for (int n = 0; n < count; n++) begin
      c = blank_cmd(pftd_pkg::FUNC_READ);
      c.x_pos = $urandom_range(PANEL_W + 8, 0) - 8;
      c.y_pos = $urandom_range(PANEL_H + 8, 0) - 8;
      c.pixel_on = $urandom_range(1, 0);
      c.char_code = $urandom_range(255, 0);
      c.byte_addr = $urandom_range(1023, 0);
      c.rect_width = $urandom_range(20, 0);
      c.rect_height = $urandom_range(20, 0);
      c.scale_x = $urandom_range(3, 0);
      c.scale_y = $urandom_range(3, 0);
      // rare full-range positions and large sizes
      if ($urandom_range(15, 0) == 0) begin
        c.x_pos = $urandom_range(511, 0);
        c.y_pos = $urandom_range(511, 0);
      end
      if ($urandom_range(40, 0) == 0) begin
        c.rect_width = $urandom_range(255, 0);
        c.rect_height = $urandom_range(255, 0);
      end
      if ($urandom_range(40, 0) == 0) begin
        c.scale_x = $urandom_range(15, 0);
        c.scale_y = $urandom_range(15, 0);
      end
      pick = $urandom_range(99, 0);
      if (pick < 2)       c.func = pftd_pkg::FUNC_CLEAR;
      else if (pick < 22) c.func = pftd_pkg::FUNC_PIXEL;
      else if (pick < 37) c.func = pftd_pkg::FUNC_FILL;
      else if (pick < 57) c.func = pftd_pkg::FUNC_GLYPH;
      else if (pick < 97) c.func = pftd_pkg::FUNC_READ;
      else                c.func = 3'($urandom_range(FUNC_SPARE_HI, FUNC_SPARE_LO));
      send_command(c, pick_gap());
      // about half of the drawing commands are followed by a readback nearby
      if (c.func inside {pftd_pkg::FUNC_PIXEL, pftd_pkg::FUNC_FILL, pftd_pkg::FUNC_GLYPH}
          && $urandom_range(1, 0))
        read_near(c.x_pos + $urandom_range(6, 0), c.y_pos + $urandom_range(8, 0));
    end
  endtask

  // Sweep every seventh byte of the store to catch anything the spot reads missed
  task automatic test_full_readback();
    for (int a = 0; a < STORE_SIZE; a += 7) send_command(read_cmd(a), 0);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_random(600);
    test_full_readback();
    @(negedge clk_i);
    start = 1'b0;
    while (pending_readouts.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("Sent %0d commands: %0d reads, %0d glyphs, with fills, pixels and clears.",
             sent_count, read_count, glyph_count);
    if (fail_count == 0 && pending_readouts.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #60_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
